/* hdl/sit_pkg.sv */
// Shared widths, types and register indexes for the segment intersection test.
// No dependencies; imported by segment_intersection_test.
package sit_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int CTOL_W  = 16;
    localparam int PTOL_W  = 32;
    localparam int BOX_W   = COORD_W + 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef logic signed [COORD_W-1:0]  t_coord;
    typedef logic signed [DIFF_W-1:0]   t_diff;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [CROSS_W-1:0]  t_cross;
    typedef logic        [CROSS_W-1:0]  t_mag;
    typedef logic        [CTOL_W-1:0]   t_ctol;
    typedef logic        [PTOL_W-1:0]   t_ptol;
    typedef logic        [2*PTOL_W-1:0] t_wide;
    typedef logic signed [BOX_W-1:0]    t_box;
    typedef logic        [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic        [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_cfg_idx CFG_COORD_TOL = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_PROD_TOL  = t_cfg_idx'(1);

endpackage

/* hdl/segment_intersection_test.sv */
// Segment intersection test: bounding-box rejection plus straddle test, six-stage pipeline.
// Depends on sit_pkg.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+--------------------------------------
//   request  | start, busy               | i_a_*_x/y, i_b_*_x/y (signed 16 bit)
//   result   | o_done (one-cycle strobe) | o_intersects
//   config   | i_cfg_valid, o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One request enters per cycle; its result strobes once it has passed the stage chain:
// differences, 17x17 products, cross sums, magnitudes, 32x32 product, final compare.
// busy stays low; nothing stalls.
// Synchronous active-low reset clears the valid chain and both tolerances.
module segment_intersection_test (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  sit_pkg::t_coord     i_a_start_x,
    input  sit_pkg::t_coord     i_a_start_y,
    input  sit_pkg::t_coord     i_a_end_x,
    input  sit_pkg::t_coord     i_a_end_y,
    input  sit_pkg::t_coord     i_b_start_x,
    input  sit_pkg::t_coord     i_b_start_y,
    input  sit_pkg::t_coord     i_b_end_x,
    input  sit_pkg::t_coord     i_b_end_y,
    output logic                o_done,
    output logic                o_intersects,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  sit_pkg::t_cfg_idx   i_cfg_index,
    input  sit_pkg::t_cfg_data  i_cfg_data
);
    import sit_pkg::*;

    localparam int NSTG = 6;

    logic [NSTG-1:0] r_vld;
    t_ctol r_ctol;
    t_ptol r_ptol;

    // stage 1
    t_diff  r_ux [4];
    t_diff  r_uy [4];
    t_diff  r_bx, r_by, r_ax, r_ay;
    t_coord r_axlo, r_axhi, r_aylo, r_ayhi, r_bxlo, r_bxhi, r_bylo, r_byhi;
    // stage 2
    t_prod  r_pa [4];
    t_prod  r_pb [4];
    logic   r_box_ok2;
    // stage 3
    t_cross r_c [4];
    logic   r_box_ok3;
    // stage 4
    logic   r_pos4 [2];
    logic   r_big4 [2];
    t_ptol  r_m1 [2];
    t_ptol  r_m2 [2];
    logic   r_box_ok4;
    // stage 5
    logic   r_pos5 [2];
    logic   r_big5 [2];
    t_wide  r_mp [2];
    logic   r_box_ok5;
    // stage 6
    logic   r_hit;

    logic   accept;
    logic   box_ok;
    t_box   tol_ext;
    t_mag   mag [4];
    logic   gt [2];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign o_done       = r_vld[NSTG-1];
    assign o_intersects = r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctol <= '0;
            r_ptol <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_COORD_TOL: r_ctol <= i_cfg_data[CTOL_W-1:0];
                CFG_PROD_TOL:  r_ptol <= i_cfg_data[PTOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NSTG-2:0], accept};
        end
    end

    // stage 1: differences and box extents
    always_ff @(posedge i_clk) begin
        r_bx <= t_diff'(i_b_end_x) - t_diff'(i_b_start_x);
        r_by <= t_diff'(i_b_end_y) - t_diff'(i_b_start_y);
        r_ax <= t_diff'(i_a_end_x) - t_diff'(i_a_start_x);
        r_ay <= t_diff'(i_a_end_y) - t_diff'(i_a_start_y);
        r_ux[0] <= t_diff'(i_a_start_x) - t_diff'(i_b_start_x);
        r_uy[0] <= t_diff'(i_a_start_y) - t_diff'(i_b_start_y);
        r_ux[1] <= t_diff'(i_a_end_x) - t_diff'(i_b_start_x);
        r_uy[1] <= t_diff'(i_a_end_y) - t_diff'(i_b_start_y);
        r_ux[2] <= t_diff'(i_b_start_x) - t_diff'(i_a_start_x);
        r_uy[2] <= t_diff'(i_b_start_y) - t_diff'(i_a_start_y);
        r_ux[3] <= t_diff'(i_b_end_x) - t_diff'(i_a_start_x);
        r_uy[3] <= t_diff'(i_b_end_y) - t_diff'(i_a_start_y);
        r_axlo <= (i_a_start_x < i_a_end_x) ? i_a_start_x : i_a_end_x;
        r_axhi <= (i_a_start_x > i_a_end_x) ? i_a_start_x : i_a_end_x;
        r_aylo <= (i_a_start_y < i_a_end_y) ? i_a_start_y : i_a_end_y;
        r_ayhi <= (i_a_start_y > i_a_end_y) ? i_a_start_y : i_a_end_y;
        r_bxlo <= (i_b_start_x < i_b_end_x) ? i_b_start_x : i_b_end_x;
        r_bxhi <= (i_b_start_x > i_b_end_x) ? i_b_start_x : i_b_end_x;
        r_bylo <= (i_b_start_y < i_b_end_y) ? i_b_start_y : i_b_end_y;
        r_byhi <= (i_b_start_y > i_b_end_y) ? i_b_start_y : i_b_end_y;
    end

    always_comb begin
        tol_ext = t_box'({2'b00, r_ctol});
        box_ok  = !(t_box'(r_axlo) > t_box'(r_bxhi) + tol_ext) &&
                  !(t_box'(r_bxlo) > t_box'(r_axhi) + tol_ext) &&
                  !(t_box'(r_aylo) > t_box'(r_byhi) + tol_ext) &&
                  !(t_box'(r_bylo) > t_box'(r_ayhi) + tol_ext);
    end

    // stage 2: partial products of the four cross products
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 2; i++) begin
            r_pa[i] <= t_prod'(r_ux[i]) * t_prod'(r_by);
            r_pb[i] <= t_prod'(r_uy[i]) * t_prod'(r_bx);
        end
        for (int i = 2; i < 4; i++) begin
            r_pa[i] <= t_prod'(r_ux[i]) * t_prod'(r_ay);
            r_pb[i] <= t_prod'(r_uy[i]) * t_prod'(r_ax);
        end
        r_box_ok2 <= box_ok;
    end

    // stage 3: cross products
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_c[i] <= t_cross'(r_pa[i]) - t_cross'(r_pb[i]);
        end
        r_box_ok3 <= r_box_ok2;
    end

    // stage 4: sign test and magnitudes
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            mag[i] = r_c[i][CROSS_W-1] ? t_mag'(-r_c[i]) : t_mag'(r_c[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 2; j++) begin
            r_pos4[j] <= (r_c[2*j] != '0) && (r_c[2*j+1] != '0) &&
                         (r_c[2*j][CROSS_W-1] == r_c[2*j+1][CROSS_W-1]);
            r_big4[j] <= (mag[2*j] > t_mag'(r_ptol)) || (mag[2*j+1] > t_mag'(r_ptol));
            r_m1[j]   <= mag[2*j][PTOL_W-1:0];
            r_m2[j]   <= mag[2*j+1][PTOL_W-1:0];
        end
        r_box_ok4 <= r_box_ok3;
    end

    // stage 5: product of magnitudes, used only when both fit the tolerance width
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 2; j++) begin
            r_mp[j]   <= t_wide'(r_m1[j]) * t_wide'(r_m2[j]);
            r_pos5[j] <= r_pos4[j];
            r_big5[j] <= r_big4[j];
        end
        r_box_ok5 <= r_box_ok4;
    end

    // stage 6: compare against tolerance and combine
    always_comb begin
        for (int j = 0; j < 2; j++) begin
            gt[j] = r_pos5[j] && (r_big5[j] || (r_mp[j] > t_wide'(r_ptol)));
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit <= r_box_ok5 && !gt[0] && !gt[1];
    end

endmodule

/* verif/sit_tb_pkg.sv */
// Request type and result tracker for the segment intersection testbench.
// Depends on sit_pkg; used by the testbench module.
package sit_tb_pkg;

    import sit_pkg::*;

    typedef struct packed {
        t_coord a_sx;
        t_coord a_sy;
        t_coord a_ex;
        t_coord a_ey;
        t_coord b_sx;
        t_coord b_sy;
        t_coord b_ex;
        t_coord b_ey;
    } t_seg_pair;

    typedef struct packed {
        t_seg_pair pair;
        logic      hit;
    } t_hit_entry;

    class t_intersect_tracker;
        t_ctol       coord_tol;
        t_ptol       prod_tol;
        t_hit_entry  expected_hits[$];
        int unsigned n_fail;

        function new();
            coord_tol = '0;
            prod_tol  = '0;
            n_fail    = 0;
        endfunction

        function longint lo2(longint a, longint b);
            return (a < b) ? a : b;
        endfunction

        function longint hi2(longint a, longint b);
            return (a > b) ? a : b;
        endfunction

        // exact product of two cross products against the product tolerance
        function bit above_prod_tol(longint c_a, longint c_b);
            logic signed [71:0] wa;
            logic signed [71:0] wb;
            logic signed [71:0] prod;
            wa   = 72'(c_a);
            wb   = 72'(c_b);
            prod = wa * wb;
            return prod > $signed({40'd0, prod_tol});
        endfunction

        function bit predict_hit(t_seg_pair p);
            longint x1, y1, x2, y2, x3, y3, x4, y4, tol;
            longint c1, c2, c3, c4;
            x1  = longint'(p.a_sx);
            y1  = longint'(p.a_sy);
            x2  = longint'(p.a_ex);
            y2  = longint'(p.a_ey);
            x3  = longint'(p.b_sx);
            y3  = longint'(p.b_sy);
            x4  = longint'(p.b_ex);
            y4  = longint'(p.b_ey);
            tol = longint'(coord_tol);
            if (lo2(x1, x2) > hi2(x3, x4) + tol || lo2(x3, x4) > hi2(x1, x2) + tol ||
                lo2(y1, y2) > hi2(y3, y4) + tol || lo2(y3, y4) > hi2(y1, y2) + tol) begin
                return 1'b0;
            end
            c1 = (x1 - x3) * (y4 - y3) - (y1 - y3) * (x4 - x3);
            c2 = (x2 - x3) * (y4 - y3) - (y2 - y3) * (x4 - x3);
            c3 = (x3 - x1) * (y2 - y1) - (y3 - y1) * (x2 - x1);
            c4 = (x4 - x1) * (y2 - y1) - (y4 - y1) * (x2 - x1);
            return !above_prod_tol(c1, c2) && !above_prod_tol(c3, c4);
        endfunction

        function void note_request(t_seg_pair p);
            t_hit_entry e;
            e.pair = p;
            e.hit  = predict_hit(p);
            expected_hits.push_back(e);
        endfunction

        function void check_result(logic got);
            t_hit_entry e;
            string      pair_txt;
            if (expected_hits.size() == 0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("unexpected result: intersects=%b with no request pending", got);
                return;
            end
            e = expected_hits.pop_front();
            if (got !== e.hit) begin
                n_fail++;
                if (n_fail <= 10) begin
                    pair_txt = $sformatf("A (%0d,%0d)-(%0d,%0d) B (%0d,%0d)-(%0d,%0d)",
                                         $signed(e.pair.a_sx), $signed(e.pair.a_sy),
                                         $signed(e.pair.a_ex), $signed(e.pair.a_ey),
                                         $signed(e.pair.b_sx), $signed(e.pair.b_sy),
                                         $signed(e.pair.b_ex), $signed(e.pair.b_ey));
                    $display("mismatch: %s ctol=%0d ptol=%0d intersects expected %b got %b",
                             pair_txt, coord_tol, prod_tol, e.hit, got);
                end
            end
        endfunction
    endclass

endpackage

/* verif/testbench.sv */
// Top-level testbench for segment_intersection_test: directed and random segment pairs,
// tolerance phases, random request gaps. Depends on sit_pkg, sit_tb_pkg and the RTL.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import sit_pkg::*;
    import sit_tb_pkg::*;

    localparam int IDLE_LIMIT = 500;
    localparam int SETTLE     = 12;
    localparam int N_RANDOM   = 1800;
    localparam int PHASES     = 8;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      start       = 1'b0;
    logic      busy;
    logic      o_done;
    logic      o_intersects;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    t_cfg_idx  i_cfg_index = '0;
    t_cfg_data i_cfg_data  = '0;
    t_seg_pair req         = '0;

    t_intersect_tracker tracker = new();
    int unsigned        idle_cycles = 0;

    segment_intersection_test dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_a_start_x  (req.a_sx),
        .i_a_start_y  (req.a_sy),
        .i_a_end_x    (req.a_ex),
        .i_a_end_y    (req.a_ey),
        .i_b_start_x  (req.b_sx),
        .i_b_start_y  (req.b_sy),
        .i_b_end_x    (req.b_ex),
        .i_b_end_y    (req.b_ey),
        .o_done       (o_done),
        .o_intersects (o_intersects),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                tracker.check_result(o_intersects);
            if (start && !busy)
                tracker.note_request(req);
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_COORD_TOL)
                    tracker.coord_tol = i_cfg_data[CTOL_W-1:0];
                else if (i_cfg_index == CFG_PROD_TOL)
                    tracker.prod_tol = i_cfg_data;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_seg_pair mk_pair(int ax0, int ay0, int ax1, int ay1,
                                          int bx0, int by0, int bx1, int by1);
        t_seg_pair p;
        p.a_sx = t_coord'(ax0);
        p.a_sy = t_coord'(ay0);
        p.a_ex = t_coord'(ax1);
        p.a_ey = t_coord'(ay1);
        p.b_sx = t_coord'(bx0);
        p.b_sy = t_coord'(by0);
        p.b_ex = t_coord'(bx1);
        p.b_ey = t_coord'(by1);
        return p;
    endfunction

    function automatic int near(int c, int span);
        return c + $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic int edge_coord();
        case ($urandom_range(0, 5))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            4: return 1;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    function automatic t_seg_pair random_pair();
        t_seg_pair p;
        int        bx, by, dx, dy, span, vx, vy, mx, my;
        int        t[4];
        bx = int'($signed(16'($urandom)));
        by = int'($signed(16'($urandom)));
        span = ($urandom_range(0, 3) == 0) ? 1000 : 8;
        case ($urandom_range(0, 9))
            0, 1: begin
                p = t_seg_pair'({$urandom, $urandom, $urandom, $urandom});
            end
            2, 3: begin
                p = mk_pair(near(bx, span), near(by, span), near(bx, span), near(by, span),
                            near(bx, span), near(by, span), near(bx, span), near(by, span));
            end
            4: begin
                dx = $urandom_range(0, 6) - 3;
                dy = $urandom_range(0, 6) - 3;
                foreach (t[k])
                    t[k] = $urandom_range(0, 8) - 4;
                p = mk_pair(bx + t[0] * dx, by + t[0] * dy, bx + t[1] * dx, by + t[1] * dy,
                            bx + t[2] * dx, by + t[2] * dy, bx + t[3] * dx, by + t[3] * dy);
            end
            5: begin
                p = mk_pair(near(bx, span), near(by, span), near(bx, span), near(by, span),
                            near(bx, span), near(by, span), near(bx, span), near(by, span));
                if ($urandom_range(0, 2) != 1) begin
                    p.a_ex = p.a_sx;
                    p.a_ey = p.a_sy;
                end
                if ($urandom_range(0, 2) != 0) begin
                    p.b_ex = p.b_sx;
                    p.b_ey = p.b_sy;
                end
            end
            6: begin
                p = mk_pair(near(bx, span), near(by, span), near(bx, span), near(by, span),
                            near(bx, span), near(by, span), near(bx, span), near(by, span));
                if ($urandom_range(0, 1) == 0) begin
                    p.b_sx = p.a_ex;
                    p.b_sy = p.a_ey;
                end else begin
                    p.b_ex = p.a_sx;
                    p.b_ey = p.a_sy;
                end
            end
            7: begin
                p = mk_pair(edge_coord(), edge_coord(), edge_coord(), edge_coord(),
                            edge_coord(), edge_coord(), edge_coord(), edge_coord());
            end
            8: begin
                p = mk_pair(near(bx, span), near(by, span), near(bx, span), near(by, span),
                            near(bx, span), near(by, span), near(bx, span), near(by, span));
                p.b_sx = t_coord'($signed(p.a_ex) + $urandom_range(0, 2) - 1);
                p.b_sy = t_coord'($signed(p.a_ey) + $urandom_range(0, 2) - 1);
            end
            default: begin
                dx = $urandom_range(0, 8000) - 4000;
                dy = $urandom_range(0, 8000) - 4000;
                mx = $urandom_range(0, 40000) - 20000;
                my = $urandom_range(0, 40000) - 20000;
                vx = $urandom_range(0, 4000) - 2000;
                vy = $urandom_range(0, 4000) - 2000;
                p = mk_pair(mx - dx, my - dy, mx + dx, my + dy,
                            mx + vx, my + vy, mx - vx, my - vy);
            end
        endcase
        return p;
    endfunction

    task automatic send_pair(t_seg_pair p, bit no_gap);
        int unsigned gap;
        gap = no_gap ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        req   <= p;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.expected_hits.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // upper bits of the coordinate tolerance word are junk on purpose
    task automatic apply_tolerances(t_ctol ctol, t_ptol ptol, bit stray);
        t_cfg_idx  idx_list[3];
        t_cfg_data val_list[3];
        int        n;
        idx_list[0] = CFG_COORD_TOL;
        val_list[0] = {16'($urandom), ctol};
        idx_list[1] = CFG_PROD_TOL;
        val_list[1] = ptol;
        idx_list[2] = t_cfg_idx'(CFG_PROD_TOL + 1 + $urandom_range(0, 1));
        val_list[2] = $urandom;
        n = stray ? 3 : 2;
        i_cfg_valid <= 1'b1;
        for (int k = 0; k < n; k++) begin
            i_cfg_index <= idx_list[k];
            i_cfg_data  <= val_list[k];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        send_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        send_pair(mk_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767), 1'b0);
        send_pair(mk_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768), 1'b0);
        send_pair(mk_pair(-100, -100, 100, 100, -100, 100, 100, -100), 1'b0);
        send_pair(mk_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768), 1'b1);
        send_pair(mk_pair(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767), 1'b0);
        send_pair(mk_pair(0, 0, 10, 0, 0, 1, 10, 1), 1'b0);
        send_pair(mk_pair(0, 0, 10, 10, 5, 5, 20, 20), 1'b1);
        send_pair(mk_pair(0, 0, 10, 10, 11, 11, 20, 20), 1'b0);
        send_pair(mk_pair(0, 0, 10, 0, 10, 0, 10, 10), 1'b0);
        send_pair(mk_pair(0, 0, 10, 0, 5, 0, 5, 10), 1'b0);
        send_pair(mk_pair(0, 0, 10, 0, 5, 1, 5, 10), 1'b1);
        send_pair(mk_pair(3, 3, 3, 3, 0, 0, 6, 6), 1'b0);
        send_pair(mk_pair(3, 4, 3, 4, 0, 0, 6, 6), 1'b0);
        send_pair(mk_pair(7, -7, 7, -7, 7, -7, 7, -7), 1'b0);
        send_pair(mk_pair(7, -7, 7, -7, 8, -7, 8, -7), 1'b0);
        send_pair(mk_pair(0, 0, 5, 5, 6, 0, 9, 9), 1'b0);
        send_pair(mk_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767), 1'b1);
        send_pair(mk_pair(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768), 1'b0);
        send_pair(mk_pair(-1, -1, 1, 1, 1, -1, -1, 1), 1'b0);
    endtask

    initial begin
        t_ctol ctol;
        t_ptol ptol;
        bit    burst;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            case (phase)
                0: begin ctol = '0;     ptol = '0;     end
                1: begin ctol = '1;     ptol = '1;     end
                2: begin ctol = 16'd1;  ptol = 32'd1;  end
                3: begin
                    ctol = t_ctol'($urandom_range(0, 15));
                    ptol = $urandom_range(0, 4095);
                end
                4: begin ctol = t_ctol'($urandom); ptol = $urandom; end
                5: begin ctol = '0;     ptol = '1;     end
                6: begin ctol = '1;     ptol = '0;     end
                default: begin
                    ctol = t_ctol'($urandom_range(0, 300));
                    ptol = $urandom_range(0, 100000);
                end
            endcase
            apply_tolerances(ctol, ptol, 1'($urandom_range(0, 1)));
            burst = 1'b0;
            for (int i = 0; i < N_RANDOM / PHASES; i++) begin
                if (i % 40 == 0)
                    burst = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 149) == 0)
                    drain_results();
                send_pair(random_pair(), burst);
            end
        end
        drain_results();
        if (tracker.n_fail == 0 && tracker.expected_hits.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
